// File: rtl/oepl_pkg.sv
// ----------------------------------------------------------------------------
// oepl_pkg
// Shared types and constants of the orphan entry pool: request and response
// structs, item kinds, result codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package oepl_pkg;

  typedef enum logic [2:0] {
    KIND_ADD        = 3'd0,
    KIND_LOOKUP     = 3'd1,
    KIND_REMOVE     = 3'd2,
    KIND_RESOLVE    = 3'd3,
    KIND_STALE      = 3'd4,
    KIND_EVICT_PEER = 3'd5,
    KIND_CLEAR      = 3'd6,
    KIND_TICK       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    STAT_ADDED        = 3'd0,
    STAT_DUPLICATE    = 3'd1,
    STAT_PARENT_KNOWN = 3'd2,
    STAT_OVER_LIMIT   = 3'd3,
    STAT_FOUND        = 3'd4,
    STAT_ABSENT       = 3'd5,
    STAT_RELEASED     = 3'd6,
    STAT_DONE         = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    CFG_MAX_ENTRIES    = 3'd0,
    CFG_MAX_SIZE_MB    = 3'd1,
    CFG_MAX_PER_SOURCE = 3'd2,
    CFG_TIMEOUT        = 3'd3,
    CFG_RESOLVE_EN     = 3'd4
  } cfg_idx_e;

  // What a walk in recency order releases
  typedef enum logic [2:0] {
    WALK_PARENT,
    WALK_PEER,
    WALK_STALE,
    WALK_EVICT,
    WALK_REMOVE
  } walk_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SWP_RD,
    S_SWP_CHK,
    S_DECIDE,
    S_WALK,
    S_RD,
    S_WCHK,
    S_INSERT,
    S_EM_RD,
    S_EM_LD,
    S_EM_WAIT
  } state_e;

  localparam logic [23:0] HEADER_BYTES   = 24'd128;
  localparam logic [23:0] BYTES_MAX      = 24'hFF_FFFF;
  localparam logic [28:0] POOL_BYTES_MAX = 29'h1FFF_FFFF;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] entry_id;
    logic [63:0] parent_id;
    logic [15:0] source_peer;
    logic [23:0] entry_bytes;
    logic        parent_known;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] out_entry_id;
    logic [63:0] out_parent_id;
    logic [15:0] out_peer;
    logic [23:0] out_bytes;
    logic [5:0]  pool_count;
    logic [28:0] pool_bytes;
    logic [5:0]  peer_count;
    logic        pool_full;
    logic        last;
  } rsp_t;

  // One word of the slot memory
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] parent;
    logic [15:0] peer;
    logic [23:0] bytes;
    logic [31:0] arrival;
  } slot_t;

endpackage

// File: rtl/oepl_ram.sv
// ----------------------------------------------------------------------------
// oepl_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module oepl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/orphan_entry_pool_lru.sv
// ----------------------------------------------------------------------------
// orphan_entry_pool_lru
// Pool of entries waiting for their parent, kept in recency order.
// ----------------------------------------------------------------------------
// Entry data sits in one slot RAM with a single read port; valid bits and
// recency ranks sit in flip-flops, so reset empties the pool at once with no
// clearing pass. One request is worked at a time. Every request ends with a
// sweep of all slots that counts the peer's entries; add, lookup and remove
// first run a second such sweep for the id search. Resolve (when enabled),
// stale sweep and peer eviction walk the ranks from the oldest entry, and each
// response goes through read, load and wait states, held in the wait state
// while the consumer stalls. The slot RAM read port, which every step shares,
// sets the pace of all of this.
module orphan_entry_pool_lru #(
  parameter int POOL_DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  oepl_pkg::req_t    req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output oepl_pkg::rsp_t    rsp_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);

  localparam int IW  = $clog2(POOL_DEPTH);
  localparam int CW  = $clog2(POOL_DEPTH + 1);
  localparam int HBW = 24 + CW;
  localparam logic [CW-1:0] DEPTH_C  = CW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(POOL_DEPTH - 1);

  // Configuration
  logic [5:0]  max_entries_q;
  logic [11:0] max_size_mb_q;
  logic [5:0]  max_per_src_q;
  logic [15:0] timeout_q;
  logic        resolve_en_q;

  // Pool state
  oepl_pkg::state_e state_q, state_d;
  oepl_pkg::req_t   req_q, req_d;
  logic [POOL_DEPTH-1:0] valid_q, valid_d;
  logic [IW-1:0]    rank_q [POOL_DEPTH];
  logic [IW-1:0]    rank_d [POOL_DEPTH];
  logic [CW-1:0]    count_q, count_d;
  logic [HBW-1:0]   bytes_q, bytes_d;
  logic [31:0]      seconds_q, seconds_d;

  // Sequencer work registers
  logic [IW-1:0]    idx_q, idx_d;
  logic             final_q, final_d;
  logic             found_q, found_d;
  logic [IW-1:0]    found_slot_q, found_slot_d;
  logic [CW-1:0]    pcnt_q, pcnt_d;
  logic [CW-1:0]    walk_r_q, walk_r_d;
  oepl_pkg::walk_e  mode_q, mode_d;
  logic [IW-1:0]    sel_q, sel_d;
  logic [IW-1:0]    list_q [POOL_DEPTH];
  logic [IW-1:0]    list_d [POOL_DEPTH];
  logic [CW-1:0]    list_n_q, list_n_d;
  oepl_pkg::status_e list_stat_q, list_stat_d;
  logic             tail_q, tail_d;
  oepl_pkg::status_e tail_stat_q, tail_stat_d;
  logic [CW-1:0]    ek_q, ek_d;
  oepl_pkg::rsp_t   rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;

  // Slot RAM
  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  oepl_pkg::slot_t     ram_wdata, rd_slot;

  oepl_ram #(
    .WIDTH ($bits(oepl_pkg::slot_t)),
    .DEPTH (POOL_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_slot)
  );

  // Limits and admission checks
  logic [24:0]   size_sum;
  logic [23:0]   size;
  logic [CW-1:0] climit;
  logic [31:0]   blimit;
  logic [32:0]   bytes_sum;
  logic          add_ok, evictable;

  assign size_sum  = {1'b0, req_q.entry_bytes} + {1'b0, oepl_pkg::HEADER_BYTES};
  assign size      = size_sum[24] ? oepl_pkg::BYTES_MAX : size_sum[23:0];
  assign climit    = ({1'b0, max_entries_q} < 7'(POOL_DEPTH)) ? CW'(max_entries_q) : DEPTH_C;
  assign blimit    = {max_size_mb_q, 20'd0};
  assign bytes_sum = 33'(bytes_q) + 33'(size);
  assign add_ok    = (count_q < climit) && (bytes_sum < {1'b0, blimit})
                     && !((pcnt_q != '0) && (7'(pcnt_q) >= 7'(max_per_src_q)));
  assign evictable = (count_q >= climit) && (count_q != '0);

  // Locate the slot at the walk rank and the lowest free slot
  logic [IW-1:0] rank_slot, free_slot;
  logic          free_hit;

  always_comb begin
    rank_slot = '0;
    free_slot = '0;
    free_hit  = 1'b0;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      if (valid_q[i] && (rank_q[i] == walk_r_q[IW-1:0])) begin
        rank_slot = IW'(i);
      end
    end
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_slot = IW'(i);
        free_hit  = 1'b1;
      end
    end
  end

  // Shared step conditions
  logic        sweep_end, walk_done, w_match, ek_in_list;
  logic [31:0] age;

  assign sweep_end  = (idx_q == LAST_IDX);
  assign walk_done  = (walk_r_q >= count_q);
  assign ek_in_list = (ek_q < list_n_q);
  assign age        = seconds_q - rd_slot.arrival;

  always_comb begin
    case (mode_q)
      oepl_pkg::WALK_PARENT: w_match = (rd_slot.parent == req_q.parent_id);
      oepl_pkg::WALK_PEER:   w_match = (rd_slot.peer == req_q.source_peer);
      oepl_pkg::WALK_STALE:  w_match = (age > {16'd0, timeout_q});
      default:               w_match = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oepl_pkg::S_IDLE: begin
        if (req_valid_i) begin
          case (req_i.kind)
            oepl_pkg::KIND_RESOLVE:    state_d = resolve_en_q ? oepl_pkg::S_WALK
                                                              : oepl_pkg::S_SWP_RD;
            oepl_pkg::KIND_STALE:      state_d = oepl_pkg::S_WALK;
            oepl_pkg::KIND_EVICT_PEER: state_d = oepl_pkg::S_WALK;
            default:                   state_d = oepl_pkg::S_SWP_RD;
          endcase
        end
      end
      oepl_pkg::S_SWP_RD: state_d = oepl_pkg::S_SWP_CHK;
      oepl_pkg::S_SWP_CHK: begin
        if (sweep_end) begin
          state_d = final_q ? oepl_pkg::S_EM_RD : oepl_pkg::S_DECIDE;
        end else begin
          state_d = oepl_pkg::S_SWP_RD;
        end
      end
      oepl_pkg::S_DECIDE: begin
        state_d = oepl_pkg::S_SWP_RD;
        case (req_q.kind)
          oepl_pkg::KIND_ADD: begin
            if (!found_q && !req_q.parent_known) begin
              if (add_ok) begin
                state_d = oepl_pkg::S_INSERT;
              end else if (evictable) begin
                state_d = oepl_pkg::S_WALK;
              end
            end
          end
          oepl_pkg::KIND_REMOVE: begin
            if (found_q) begin
              state_d = oepl_pkg::S_RD;
            end
          end
          default: state_d = oepl_pkg::S_SWP_RD;
        endcase
      end
      oepl_pkg::S_WALK: state_d = walk_done ? oepl_pkg::S_SWP_RD : oepl_pkg::S_RD;
      oepl_pkg::S_RD:   state_d = oepl_pkg::S_WCHK;
      oepl_pkg::S_WCHK: begin
        if (w_match) begin
          case (mode_q)
            oepl_pkg::WALK_EVICT:  state_d = oepl_pkg::S_INSERT;
            oepl_pkg::WALK_REMOVE: state_d = oepl_pkg::S_SWP_RD;
            default:               state_d = oepl_pkg::S_WALK;
          endcase
        end else begin
          state_d = (mode_q == oepl_pkg::WALK_STALE) ? oepl_pkg::S_SWP_RD
                                                     : oepl_pkg::S_WALK;
        end
      end
      oepl_pkg::S_INSERT:  state_d = oepl_pkg::S_SWP_RD;
      oepl_pkg::S_EM_RD:   state_d = oepl_pkg::S_EM_LD;
      oepl_pkg::S_EM_LD:   state_d = oepl_pkg::S_EM_WAIT;
      oepl_pkg::S_EM_WAIT: begin
        if (rsp_ready_i) begin
          state_d = rsp_q.last ? oepl_pkg::S_IDLE : oepl_pkg::S_EM_RD;
        end
      end
      default: state_d = oepl_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  logic          mod_en, touch_en;
  logic [IW-1:0] mod_slot;
  logic [IW-1:0] mod_rank;

  always_comb begin
    req_d        = req_q;
    valid_d      = valid_q;
    rank_d       = rank_q;
    count_d      = count_q;
    bytes_d      = bytes_q;
    seconds_d    = seconds_q;
    idx_d        = idx_q;
    final_d      = final_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    pcnt_d       = pcnt_q;
    walk_r_d     = walk_r_q;
    mode_d       = mode_q;
    sel_d        = sel_q;
    list_d       = list_q;
    list_n_d     = list_n_q;
    list_stat_d  = list_stat_q;
    tail_d       = tail_q;
    tail_stat_d  = tail_stat_q;
    ek_d         = ek_q;
    rsp_d        = rsp_q;
    rsp_valid_d  = rsp_valid_q;
    ram_we       = 1'b0;
    ram_waddr    = free_slot;
    ram_raddr    = idx_q;
    ram_wdata    = '{id: req_q.entry_id, parent: req_q.parent_id,
                     peer: req_q.source_peer, bytes: size, arrival: seconds_q};
    mod_en       = 1'b0;
    touch_en     = 1'b0;
    mod_slot     = sel_q;

    case (state_q)
      // Latch the request and set up its work; clear empties the pool and tick advances the seconds
      oepl_pkg::S_IDLE: begin
        if (req_valid_i) begin
          req_d       = req_i;
          list_n_d    = '0;
          ek_d        = '0;
          walk_r_d    = '0;
          tail_d      = 1'b1;
          tail_stat_d = oepl_pkg::STAT_DONE;
          list_stat_d = oepl_pkg::STAT_RELEASED;
          case (req_i.kind)
            oepl_pkg::KIND_ADD:        tail_d = 1'b0;
            oepl_pkg::KIND_LOOKUP:     tail_d = 1'b0;
            oepl_pkg::KIND_REMOVE:     tail_d = 1'b0;
            oepl_pkg::KIND_RESOLVE:    mode_d = oepl_pkg::WALK_PARENT;
            oepl_pkg::KIND_STALE:      mode_d = oepl_pkg::WALK_STALE;
            oepl_pkg::KIND_EVICT_PEER: mode_d = oepl_pkg::WALK_PEER;
            oepl_pkg::KIND_CLEAR: begin
              valid_d = '0;
              count_d = '0;
              bytes_d = '0;
            end
            default: seconds_d = seconds_q + 32'd1;
          endcase
        end
      end
      oepl_pkg::S_SWP_RD: ram_raddr = idx_q;
      // Match the id and count the peer's entries
      oepl_pkg::S_SWP_CHK: begin
        if (valid_q[idx_q]) begin
          if ((rd_slot.id == req_q.entry_id) && !found_q) begin
            found_d      = 1'b1;
            found_slot_d = idx_q;
          end
          if (rd_slot.peer == req_q.source_peer) begin
            pcnt_d = pcnt_q + CW'(1);
          end
        end
        if (!sweep_end) begin
          idx_d = idx_q + IW'(1);
        end
      end
      oepl_pkg::S_DECIDE: begin
        case (req_q.kind)
          oepl_pkg::KIND_ADD: begin
            if (found_q) begin
              tail_d      = 1'b1;
              tail_stat_d = oepl_pkg::STAT_DUPLICATE;
            end else if (req_q.parent_known) begin
              tail_d      = 1'b1;
              tail_stat_d = oepl_pkg::STAT_PARENT_KNOWN;
            end else if (!add_ok && evictable) begin
              mode_d   = oepl_pkg::WALK_EVICT;
              walk_r_d = '0;
            end else if (!add_ok) begin
              tail_d      = 1'b1;
              tail_stat_d = oepl_pkg::STAT_OVER_LIMIT;
            end
          end
          oepl_pkg::KIND_LOOKUP: begin
            if (found_q) begin
              touch_en                 = 1'b1;
              mod_en                   = 1'b1;
              mod_slot                 = found_slot_q;
              list_d[list_n_q[IW-1:0]] = found_slot_q;
              list_n_d                 = list_n_q + CW'(1);
              list_stat_d              = oepl_pkg::STAT_FOUND;
            end else begin
              tail_d      = 1'b1;
              tail_stat_d = oepl_pkg::STAT_ABSENT;
            end
          end
          default: begin
            if (found_q) begin
              sel_d       = found_slot_q;
              mode_d      = oepl_pkg::WALK_REMOVE;
              list_stat_d = oepl_pkg::STAT_RELEASED;
            end else begin
              tail_d      = 1'b1;
              tail_stat_d = oepl_pkg::STAT_ABSENT;
            end
          end
        endcase
      end
      oepl_pkg::S_WALK: begin
        if (!walk_done) begin
          sel_d = rank_slot;
        end
      end
      oepl_pkg::S_RD: ram_raddr = sel_q;
      // Drop a matching entry, or step to the next rank (a stale walk stops at the first entry that is not stale)
      oepl_pkg::S_WCHK: begin
        if (w_match) begin
          mod_en            = 1'b1;
          valid_d[sel_q]    = 1'b0;
          count_d           = count_q - CW'(1);
          bytes_d           = bytes_q - HBW'(rd_slot.bytes);
          if (mode_q != oepl_pkg::WALK_EVICT) begin
            list_d[list_n_q[IW-1:0]] = sel_q;
            list_n_d                 = list_n_q + CW'(1);
          end
        end else if (mode_q != oepl_pkg::WALK_STALE) begin
          walk_r_d = walk_r_q + CW'(1);
        end
      end
      // Place the new entry as the newest
      oepl_pkg::S_INSERT: begin
        tail_d = 1'b1;
        if (free_hit) begin
          ram_we            = 1'b1;
          valid_d[free_slot] = 1'b1;
          rank_d[free_slot] = count_q[IW-1:0];
          count_d           = count_q + CW'(1);
          bytes_d           = bytes_q + HBW'(size);
          tail_stat_d       = oepl_pkg::STAT_ADDED;
        end else begin
          tail_stat_d = oepl_pkg::STAT_OVER_LIMIT;
        end
      end
      oepl_pkg::S_EM_RD: begin
        ram_raddr = ek_in_list ? list_q[ek_q[IW-1:0]] : '0;
      end
      // Load the response register
      oepl_pkg::S_EM_LD: begin
        rsp_valid_d = 1'b1;
        if (ek_in_list) begin
          rsp_d.status        = list_stat_q;
          rsp_d.out_entry_id  = rd_slot.id;
          rsp_d.out_parent_id = rd_slot.parent;
          rsp_d.out_peer      = rd_slot.peer;
          rsp_d.out_bytes     = rd_slot.bytes;
          rsp_d.last          = !tail_q && (ek_q == list_n_q - CW'(1));
        end else begin
          rsp_d.status        = tail_stat_q;
          rsp_d.out_entry_id  = '0;
          rsp_d.out_parent_id = '0;
          rsp_d.out_peer      = '0;
          rsp_d.out_bytes     = '0;
          rsp_d.last          = 1'b1;
        end
        rsp_d.pool_count = 6'(count_q);
        rsp_d.pool_bytes = (32'(bytes_q) > 32'(oepl_pkg::POOL_BYTES_MAX))
                           ? oepl_pkg::POOL_BYTES_MAX : 29'(bytes_q);
        rsp_d.peer_count = 6'(pcnt_q);
        rsp_d.pool_full  = (7'(count_q) >= 7'(max_entries_q))
                           || (32'(bytes_q) >= blimit);
      end
      oepl_pkg::S_EM_WAIT: begin
        if (rsp_ready_i) begin
          rsp_valid_d = 1'b0;
          ek_d        = ek_q + CW'(1);
        end
      end
      default: ;
    endcase

    // Close the rank gap on drop, or move a touched entry to newest
    mod_rank = rank_q[mod_slot];
    if (mod_en) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        if (valid_q[i] && (rank_q[i] > mod_rank)) begin
          rank_d[i] = rank_q[i] - IW'(1);
        end
      end
      if (touch_en) begin
        rank_d[mod_slot] = IW'(count_q - CW'(1));
      end
    end

    // Restart the slot sweep when entering it
    if ((state_d == oepl_pkg::S_SWP_RD) && (state_q != oepl_pkg::S_SWP_CHK)) begin
      idx_d   = '0;
      pcnt_d  = '0;
      found_d = 1'b0;
      final_d = !((state_q == oepl_pkg::S_IDLE)
                  && ((req_i.kind == oepl_pkg::KIND_ADD)
                      || (req_i.kind == oepl_pkg::KIND_LOOKUP)
                      || (req_i.kind == oepl_pkg::KIND_REMOVE)));
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= 6'd32;
      max_size_mb_q <= 12'd32;
      max_per_src_q <= 6'd8;
      timeout_q     <= 16'd600;
      resolve_en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        oepl_pkg::CFG_MAX_ENTRIES:    max_entries_q <= cfg_data_i[5:0];
        oepl_pkg::CFG_MAX_SIZE_MB:    max_size_mb_q <= cfg_data_i[11:0];
        oepl_pkg::CFG_MAX_PER_SOURCE: max_per_src_q <= cfg_data_i[5:0];
        oepl_pkg::CFG_TIMEOUT:        timeout_q     <= cfg_data_i;
        oepl_pkg::CFG_RESOLVE_EN:     resolve_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oepl_pkg::S_IDLE;
      valid_q     <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      seconds_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      seconds_q   <= seconds_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Work and payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    rank_q       <= rank_d;
    idx_q        <= idx_d;
    final_q      <= final_d;
    found_q      <= found_d;
    found_slot_q <= found_slot_d;
    pcnt_q       <= pcnt_d;
    walk_r_q     <= walk_r_d;
    mode_q       <= mode_d;
    sel_q        <= sel_d;
    list_q       <= list_d;
    list_n_q     <= list_n_d;
    list_stat_q  <= list_stat_d;
    tail_q       <= tail_d;
    tail_stat_q  <= tail_stat_d;
    ek_q         <= ek_d;
    rsp_q        <= rsp_d;
  end

  assign req_ready_o = (state_q == oepl_pkg::S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Checks
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(count_q))
    else $error("held count differs from number of valid slots");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("held count above pool depth");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> !rsp_valid_o)
    else $error("request taken while a response is pending");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_ready_i && rsp_o.last) |=> req_ready_o)
    else $error("not ready after final response");

endmodule
